FILE: rtl/core/cvdf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cvdf_pkg
// Types, mode codes and coefficient matrices of the color vision filter.
// ============================================================================
package cvdf_pkg;

    // filter mode register
    localparam int unsigned MODE_W = 3;
    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_NORMAL     = 3'd0;
    localparam t_mode MODE_PROTANOPIA = 3'd1;
    localparam t_mode MODE_DEUTAN     = 3'd2;
    localparam t_mode MODE_TRITANOPIA = 3'd3;
    localparam t_mode MODE_MONO       = 3'd4;

    // apb side
    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_FILTER_MODE = 2'd0;

    // datapath widths
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned COEF_W = 16;   // unsigned q0.16
    localparam int unsigned PROD_W = CHAN_W + COEF_W;
    localparam int unsigned SUM_W  = PROD_W + 2;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [COEF_W-1:0] t_coef;
    typedef logic [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha;
    } t_pixel;

    // rows give red, green, blue out; columns weight red, green, blue in
    typedef t_coef [0:2][0:2] t_matrix;

    // products travelling from the multiplier stage to the summing stage
    typedef struct packed {
        t_prod [0:2][0:2] prod;
        logic             pass;
        t_pixel           pix;
    } t_prod_beat;

    // coefficient matrix of a mode, zero where the pixel passes through
    function automatic t_matrix coef_matrix(t_mode mode);
        t_matrix m;
        unique case (mode)
            MODE_PROTANOPIA: m = '{'{16'd37159, 16'd28377, 16'd0},
                                   '{16'd36569, 16'd28967, 16'd0},
                                   '{16'd0,     16'd15860, 16'd49676}};
            MODE_DEUTAN:     m = '{'{16'd40960, 16'd24576, 16'd0},
                                   '{16'd45875, 16'd19661, 16'd0},
                                   '{16'd0,     16'd19661, 16'd45875}};
            MODE_TRITANOPIA: m = '{'{16'd62259, 16'd3277,  16'd0},
                                   '{16'd0,     16'd28377, 16'd37159},
                                   '{16'd0,     16'd31130, 16'd34406}};
            MODE_MONO:       m = '{'{16'd19595, 16'd38470, 16'd7471},
                                   '{16'd19595, 16'd38470, 16'd7471},
                                   '{16'd19595, 16'd38470, 16'd7471}};
            default:         m = '0;
        endcase
        return m;
    endfunction

    // modes outside the matrix set pass the pixel unchanged
    function automatic logic is_pass(t_mode mode);
        return !(mode == MODE_PROTANOPIA || mode == MODE_DEUTAN ||
                 mode == MODE_TRITANOPIA || mode == MODE_MONO);
    endfunction

endpackage

FILE: rtl/core/cvdf_if.sv
`timescale 1ns / 1ps
// ============================================================================
// cvdf pixel interfaces
// Valid/ready pixel channels into and out of the color vision filter.
// ============================================================================
interface cvdf_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface cvdf_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

FILE: rtl/core/color_vision_deficiency_filter.sv
`timescale 1ns / 1ps
// pipeline from input beat to output beat: select, multiply and sum stages
// throughput: one pixel per cycle while the output is not stalled, each stage is a full register stage
// ready is combinational back through all stages; a waiting output blocks input once full
// reset: synchronous active-low, empties all pipeline stages, mode returns to normal
// ============================================================================
// color_vision_deficiency_filter
// RGBA color blindness simulation matrix with APB mode register.
// ============================================================================
module color_vision_deficiency_filter
    import cvdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    cvdf_pix_in_if.sink           i_pix,
    cvdf_pix_out_if.source        o_pix
);

    t_mode      mode;
    logic       prod_valid;
    logic       prod_ready;
    t_prod_beat prod_beat;

    // mode register
    cvdf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (mode)
    );

    // select and multiply stages
    cvdf_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (mode),
        .i_pix   (i_pix),
        .o_valid (prod_valid),
        .i_ready (prod_ready),
        .o_beat  (prod_beat)
    );

    // sum, saturate and output stage
    cvdf_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_beat  (prod_beat),
        .o_pix   (o_pix)
    );

endmodule

FILE: rtl/core/cvdf_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// cvdf_cfg
// APB register file holding the filter mode.
// ============================================================================
module cvdf_cfg
    import cvdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_mode                 o_mode
);

    t_mode r_mode;
    logic  wr_en;

    // single register, every write lands in it
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (wr_en) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    // readback, zero on unaligned byte offsets
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_FILTER_MODE) begin
            prdata = {{(APB_DATA_W-MODE_W){1'b0}}, r_mode};
        end
    end

    assign o_mode = r_mode;

endmodule

FILE: rtl/core/cvdf_mult.sv
`timescale 1ns / 1ps
// ============================================================================
// cvdf_mult
// Coefficient select stage followed by the nine-product multiplier stage.
// ============================================================================
module cvdf_mult
    import cvdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mode       i_mode,
    cvdf_pix_in_if.sink i_pix,
    output logic        o_valid,
    input  logic        i_ready,
    output t_prod_beat  o_beat
);

    logic                   r_s1_valid;
    t_pixel                 r_s1_pix;
    t_matrix                r_s1_coef;
    logic                   r_s1_pass;
    logic                   r_s2_valid;
    t_prod_beat             r_s2_beat;
    logic                   s1_ready;
    logic                   s2_ready;
    t_chan [0:2]            s1_chan;
    t_prod [0:2][0:2]       n_prod;

    // stage advances when empty or when the stage after it moves
    assign s2_ready    = !r_s2_valid || i_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_ready;

    // stage 1: capture pixel and the matrix for the current mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_pix.valid) begin
            r_s1_pix  <= '{red:   i_pix.red_in,  green: i_pix.green_in,
                            blue:  i_pix.blue_in, alpha: i_pix.alpha_in};
            r_s1_coef <= coef_matrix(i_mode);
            r_s1_pass <= is_pass(i_mode);
        end
    end

    // stage 2: nine 16x8 products
    assign s1_chan = {r_s1_pix.red, r_s1_pix.green, r_s1_pix.blue};

    always_comb begin
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
                n_prod[row][col] = PROD_W'(r_s1_coef[row][col]) * PROD_W'(s1_chan[col]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_beat.prod <= n_prod;
            r_s2_beat.pass <= r_s1_pass;
            r_s2_beat.pix  <= r_s1_pix;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_beat  = r_s2_beat;

    // a held stage keeps its beat
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> (r_s1_valid && $stable(r_s1_pix)))
        else $error("stage 1 beat lost under stall");

    // passing modes carry an all-zero matrix
    a_pass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_pass) |-> (r_s1_coef == '0))
        else $error("pass-through beat with nonzero coefficients");

endmodule

FILE: rtl/core/cvdf_acc.sv
`timescale 1ns / 1ps
// ============================================================================
// cvdf_acc
// Row summing, q0.16 truncation, saturation and the output register.
// ============================================================================
module cvdf_acc
    import cvdf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_prod_beat    i_beat,
    cvdf_pix_out_if.source o_pix
);

    logic                 r_valid;
    t_pixel               r_pix;
    logic [SUM_W-1:0]     row_sum [3];
    t_chan [0:2]          n_chan;
    logic [SUM_W-17:0]    row_int [3];

    assign o_ready = !r_valid || o_pix.ready;

    // sum each row, drop the fraction, clamp to 255
    always_comb begin
        for (int row = 0; row < 3; row++) begin
            row_sum[row] = SUM_W'(i_beat.prod[row][0]) + SUM_W'(i_beat.prod[row][1])
                         + SUM_W'(i_beat.prod[row][2]);
            row_int[row] = row_sum[row][SUM_W-1:16];
            n_chan[row]  = (|row_int[row][SUM_W-17:CHAN_W]) ? {CHAN_W{1'b1}}
                                                             : row_int[row][CHAN_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            if (i_beat.pass) begin
                r_pix <= i_beat.pix;
            end else begin
                r_pix <= '{red: n_chan[0], green: n_chan[1], blue: n_chan[2],
                           alpha: i_beat.pix.alpha};
            end
        end
    end

    assign o_pix.valid     = r_valid;
    assign o_pix.red_out   = r_pix.red;
    assign o_pix.green_out = r_pix.green;
    assign o_pix.blue_out  = r_pix.blue;
    assign o_pix.alpha_out = r_pix.alpha;

    // rows sum to unity, so a sum never reaches the top two bits
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (row_sum[0][SUM_W-1:SUM_W-2] == 2'b00 &&
                     row_sum[1][SUM_W-1:SUM_W-2] == 2'b00 &&
                     row_sum[2][SUM_W-1:SUM_W-2] == 2'b00))
        else $error("row sum exceeded unity gain");

    // backpressure only while a result is waiting
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_valid && !o_pix.ready))
        else $error("stage stalled with nothing waiting");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("output valid after reset");

endmodule
